// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// Implication checked in the cycle after the condition holds.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

// File: rtl/core/cmp_pkg.sv
// Package with shared types, constants and element table of the card message parser.
package cmp_pkg;
  localparam logic [2:0] ROLE_TYPE   = 3'd0;
  localparam logic [2:0] ROLE_BITMAP = 3'd1;
  localparam logic [2:0] ROLE_PREFIX = 3'd2;
  localparam logic [2:0] ROLE_DATA   = 3'd3;
  localparam logic [2:0] ROLE_IGNORE = 3'd4;

  localparam logic [3:0] ST_PENDING  = 4'd0;
  localparam logic [3:0] ST_OK       = 4'd1;
  localparam logic [3:0] ST_TRUNC    = 4'd2;
  localparam logic [3:0] ST_TYPE     = 4'd3;
  localparam logic [3:0] ST_HEX      = 4'd4;
  localparam logic [3:0] ST_UNSUPP   = 4'd5;
  localparam logic [3:0] ST_PREFIX   = 4'd6;
  localparam logic [3:0] ST_LENGTH   = 4'd7;
  localparam logic [3:0] ST_NUMERIC  = 4'd8;
  localparam logic [3:0] ST_OVERFLOW = 4'd9;
  localparam logic [3:0] ST_TRAILING = 4'd10;

  localparam logic [0:0] CFG_CARD_MAX  = 1'b0;
  localparam logic [0:0] CFG_EXTRA_MAX = 1'b1;

  localparam logic [1:0] LAY_FIXED = 2'd0;
  localparam logic [1:0] LAY_LL    = 2'd1;
  localparam logic [1:0] LAY_LLL   = 2'd2;
  localparam logic [1:0] LAY_NONE  = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [6:0]  element_number;
    logic [9:0]  field_offset;
    logic [7:0]  byte_out;
    logic        message_end;
    logic [3:0]  status;
    logic [31:0] amount_value;
    logic [6:0]  card_number_length;
    logic [9:0]  extra_data_length;
    logic [63:0] present_map;
  } out_item_t;

  // Classified byte handed from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] nibble;
  } cls_item_t;

  typedef struct packed {
    logic [1:0] layout;
    logic [3:0] size;
    logic       digits_only;
  } elem_desc_t;

  function automatic elem_desc_t elem_lookup(input logic [6:0] e);
    elem_desc_t d;
    d = '{layout: LAY_NONE, size: 4'd0, digits_only: 1'b0};
    case (e)
      7'd2:  d = '{LAY_LL, 4'd0, 1'b1};
      7'd3:  d = '{LAY_FIXED, 4'd6, 1'b1};
      7'd4:  d = '{LAY_FIXED, 4'd12, 1'b1};
      7'd7:  d = '{LAY_FIXED, 4'd10, 1'b1};
      7'd11: d = '{LAY_FIXED, 4'd6, 1'b1};
      7'd12: d = '{LAY_FIXED, 4'd6, 1'b1};
      7'd13: d = '{LAY_FIXED, 4'd4, 1'b1};
      7'd38: d = '{LAY_FIXED, 4'd6, 1'b0};
      7'd39: d = '{LAY_FIXED, 4'd2, 1'b0};
      7'd41: d = '{LAY_FIXED, 4'd8, 1'b0};
      7'd42: d = '{LAY_FIXED, 4'd15, 1'b0};
      7'd48: d = '{LAY_LLL, 4'd0, 1'b0};
      7'd49: d = '{LAY_FIXED, 4'd3, 1'b1};
      default: d = '{LAY_NONE, 4'd0, 1'b0};
    endcase
    return d;
  endfunction
endpackage

// File: rtl/core/cmp_if.sv
// Valid/ready channel interfaces of the card message parser.
interface cmp_in_if;
  logic               valid;
  logic               ready;
  cmp_pkg::in_item_t  payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface cmp_out_if;
  logic               valid;
  logic               ready;
  cmp_pkg::out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface cmp_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [9:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/core/cmp_front.sv
// Front end: accepts bytes, classifies them and queues them for the walker.
module cmp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  cmp_in_if.sink              in_ch,
  output logic                q_valid_o,
  output cmp_pkg::cls_item_t  q_item_o,
  input  logic                q_pop_i
);
  import cmp_pkg::*;

  cls_item_t       mem_q [QUEUE_DEPTH];
  logic            wr_q, wr_d, rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;
  cls_item_t       cls;
  logic            push;
  logic [7:0]      c;

  assign c = in_ch.payload.data_byte;
  always_comb begin
    cls.data_byte = c;
    cls.last_byte = in_ch.payload.last_byte;
    cls.is_dec    = (c >= 8'h30) && (c <= 8'h39);
    cls.is_hex    = 1'b1;
    cls.nibble    = 4'd0;
    if (cls.is_dec) begin
      cls.nibble = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      cls.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      cls.is_hex = 1'b0;
    end
  end

  assign in_ch.ready = (cnt_q != 2'(QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = mem_q[rd_q];

  always_comb begin
    wr_d = push ? !wr_q : wr_q;
    rd_d = q_pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// File: rtl/core/cmp_back.sv
// Back end: walks header and elements, one classified byte per cycle while not scanning and the output is free.
module cmp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cmp_pkg::cls_item_t  q_item_i,
  output logic                q_pop_o,
  input  logic [6:0]          card_max_i,
  input  logic [9:0]          extra_max_i,
  cmp_out_if.source           out_ch
);
  import cmp_pkg::*;

  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_BITMAP = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_SEEK   = 3'd5;
  localparam logic [2:0] PH_HALT   = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  hidx_q, hidx_d;
  logic [63:0] map_q, map_d;
  logic [6:0]  elem_q, elem_d;
  logic [9:0]  pval_q, pval_d;
  logic [1:0]  pleft_q, pleft_d;
  logic [9:0]  bleft_q, bleft_d;
  logic [9:0]  off_q, off_d;
  logic [31:0] amt_q, amt_d;
  logic [6:0]  clen_q, clen_d;
  logic [9:0]  xlen_q, xlen_d;
  logic [3:0]  err_q, err_d;
  out_item_t   res_q, res_d;
  logic        ov_q, ov_d;
  logic        dfr_q, dfr_d;

  logic        take, seek;
  logic [6:0]  seek_start;
  logic [2:0]  role;
  logic [6:0]  oelem;
  logic [9:0]  ooff;
  logic [3:0]  st;
  logic [13:0] pv_next;
  logic [35:0] amt_next;
  logic [9:0]  limit;
  elem_desc_t  cur_d, seek_d;
  logic        bit_set;
  logic [5:0]  bit_idx;

  // Element walk steps one candidate number per cycle while the queue waits.
  assign take = q_valid_i && (phase_q != PH_SEEK) && (!ov_q || out_ch.ready);
  assign q_pop_o = take;
  assign out_ch.valid = ov_q;
  assign out_ch.payload = res_q;

  assign cur_d = elem_lookup(elem_q);
  assign seek_d = elem_lookup(elem_q);
  assign bit_idx = 6'(7'd64 - elem_q);
  assign bit_set = map_q[bit_idx];
  assign pv_next = 14'(pval_q) * 14'd10 + 14'(q_item_i.data_byte[3:0]);
  assign amt_next = 36'(amt_q) * 36'd10 + 36'(q_item_i.data_byte[3:0]);
  assign limit = (elem_q == 7'd2) ? 10'(card_max_i) : extra_max_i;

  always_comb begin
    phase_d = phase_q; hidx_d = hidx_q; map_d = map_q; elem_d = elem_q;
    pval_d = pval_q; pleft_d = pleft_q; bleft_d = bleft_q; off_d = off_q;
    amt_d = amt_q; clen_d = clen_q; xlen_d = xlen_q; err_d = err_q;
    res_d = res_q; ov_d = ov_q && !out_ch.ready; dfr_d = dfr_q;
    role = ROLE_IGNORE; oelem = 7'd0; ooff = 10'd0; st = ST_PENDING;
    seek = 1'b0; seek_start = 7'd0;

    if (phase_q == PH_SEEK) begin
      // Examine candidate elem_q.
      if (elem_q == 7'd65) begin
        elem_d = 7'd0;
        phase_d = PH_DONE;
      end else if (bit_set) begin
        off_d = 10'd0;
        case (seek_d.layout)
          LAY_FIXED: begin
            bleft_d = 10'(seek_d.size);
            phase_d = PH_DATA;
          end
          LAY_LL: begin
            pleft_d = 2'd2; pval_d = 10'd0; phase_d = PH_PREFIX;
          end
          LAY_LLL: begin
            pleft_d = 2'd3; pval_d = 10'd0; phase_d = PH_PREFIX;
          end
          default: begin
            if (err_q == ST_PENDING) err_d = ST_UNSUPP;
            phase_d = PH_HALT;
          end
        endcase
      end else begin
        elem_d = elem_q + 7'd1;
      end
    end else if (take) begin
      case (phase_q)
        PH_TYPE: begin
          role = ROLE_TYPE; ooff = 10'(hidx_q);
          if (!q_item_i.is_dec) begin
            err_d = ST_TYPE; phase_d = PH_HALT;
          end else begin
            hidx_d = hidx_q + 5'd1;
            if (hidx_q == 5'd3) phase_d = PH_BITMAP;
          end
        end
        PH_BITMAP: begin
          role = ROLE_BITMAP; ooff = 10'(hidx_q);
          if (!q_item_i.is_hex) begin
            err_d = ST_HEX; phase_d = PH_HALT;
          end else begin
            map_d = {map_q[59:0], q_item_i.nibble};
            hidx_d = hidx_q + 5'd1;
            if (hidx_q == 5'd19) begin
              seek = 1'b1; seek_start = 7'd1;
            end
          end
        end
        PH_PREFIX: begin
          role = ROLE_PREFIX; oelem = elem_q; ooff = off_q;
          if (!q_item_i.is_dec) begin
            err_d = ST_PREFIX; phase_d = PH_HALT;
          end else begin
            pval_d = pv_next[9:0];
            off_d = off_q + 10'd1;
            pleft_d = pleft_q - 2'd1;
            if (pleft_q == 2'd1) begin
              if (pv_next > 14'(limit)) begin
                err_d = ST_LENGTH; phase_d = PH_HALT;
              end else begin
                if (elem_q == 7'd2) clen_d = pv_next[6:0];
                else xlen_d = pv_next[9:0];
                bleft_d = pv_next[9:0];
                off_d = 10'd0;
                if (pv_next == 14'd0) begin
                  seek = 1'b1; seek_start = elem_q + 7'd1;
                end else begin
                  phase_d = PH_DATA;
                end
              end
            end
          end
        end
        PH_DATA: begin
          role = ROLE_DATA; oelem = elem_q; ooff = off_q;
          if (cur_d.digits_only && !q_item_i.is_dec) begin
            err_d = ST_NUMERIC; phase_d = PH_HALT;
          end else if (elem_q == 7'd4 && amt_next[35:32] != 4'd0) begin
            err_d = ST_OVERFLOW; phase_d = PH_HALT;
          end else begin
            if (elem_q == 7'd4) amt_d = amt_next[31:0];
            off_d = off_q + 10'd1;
            bleft_d = bleft_q - 10'd1;
            if (bleft_q == 10'd1) begin
              seek = 1'b1; seek_start = elem_q + 7'd1;
            end
          end
        end
        PH_DONE: begin
          if (err_q == ST_PENDING) err_d = ST_TRAILING;
          phase_d = PH_HALT;
        end
        default: begin
        end
      endcase
      if (seek) begin
        elem_d = seek_start;
        phase_d = PH_SEEK;
      end
      // A last byte that ends on a seek resolves the walk before status.
      if (q_item_i.last_byte) begin
        if (err_d != ST_PENDING) st = err_d;
        else if (phase_d == PH_DONE) st = ST_OK;
        else if (seek && !(|(map_d << (seek_start - 7'd1)) ) ) st = ST_OK;
        else if (seek) st = ST_PENDING;
        else st = ST_TRUNC;
      end else begin
        st = err_d;
      end
      res_d.byte_role = role; res_d.element_number = oelem;
      res_d.field_offset = ooff; res_d.byte_out = q_item_i.data_byte;
      res_d.message_end = q_item_i.last_byte; res_d.status = st;
      res_d.amount_value = amt_d; res_d.card_number_length = clen_d;
      res_d.extra_data_length = xlen_d; res_d.present_map = map_d;
      ov_d = 1'b1;
      if (seek && st == ST_PENDING) begin
        // The scan may still hit an unsupported element, so the result waits for it.
        ov_d = 1'b0;
        dfr_d = 1'b1;
      end else if (q_item_i.last_byte) begin
        phase_d = PH_TYPE; hidx_d = 5'd0; map_d = 64'd0; elem_d = 7'd0;
        pval_d = 10'd0; pleft_d = 2'd0; bleft_d = 10'd0; off_d = 10'd0;
        amt_d = 32'd0; clen_d = 7'd0; xlen_d = 10'd0; err_d = ST_PENDING;
      end
    end
    if (phase_q == PH_SEEK && dfr_q && phase_d != PH_SEEK) begin
      // Held status: the walk has now either found an element or ended.
      if (err_d != ST_PENDING) res_d.status = err_d;
      else if (!res_q.message_end) res_d.status = ST_PENDING;
      else if (phase_d == PH_DONE) res_d.status = ST_OK;
      else res_d.status = ST_TRUNC;
      ov_d = 1'b1;
      dfr_d = 1'b0;
      if (res_q.message_end) begin
        phase_d = PH_TYPE; hidx_d = 5'd0; map_d = 64'd0; elem_d = 7'd0;
        pval_d = 10'd0; pleft_d = 2'd0; bleft_d = 10'd0; off_d = 10'd0;
        amt_d = 32'd0; clen_d = 7'd0; xlen_d = 10'd0; err_d = ST_PENDING;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE; hidx_q <= 5'd0; map_q <= 64'd0; elem_q <= 7'd0;
      pval_q <= 10'd0; pleft_q <= 2'd0; bleft_q <= 10'd0; off_q <= 10'd0;
      amt_q <= 32'd0; clen_q <= 7'd0; xlen_q <= 10'd0; err_q <= ST_PENDING;
      ov_q <= 1'b0; dfr_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hidx_q <= hidx_d; map_q <= map_d; elem_q <= elem_d;
      pval_q <= pval_d; pleft_q <= pleft_d; bleft_q <= bleft_d; off_q <= off_d;
      amt_q <= amt_d; clen_q <= clen_d; xlen_q <= xlen_d; err_q <= err_d;
      ov_q <= ov_d; dfr_q <= dfr_d;
    end
  end
endmodule

// File: rtl/core/card_message_parser_core.sv
// Top level of the card message parser.
// Bytes enter through a two-entry queue and leave through one output register.
// After the byte that ends the bitmap or an element, the walker scans the
// bitmap one element number per cycle to the next present element or to the
// end of the map. The result of the byte that starts a scan is held until the
// scan ends, unless it is the last byte and no present element follows. The
// queue keeps accepting bytes during that scan until it is full.
module card_message_parser_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cmp_in_if.sink    in_ch,
  cmp_out_if.source out_ch,
  cmp_cfg_if.sink   cfg_ch
);
  import cmp_pkg::*;

  logic [6:0] card_max_q;
  logic [9:0] extra_max_q;
  logic       q_valid, q_pop;
  cls_item_t  q_item;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_max_q <= 7'd19;
      extra_max_q <= 10'd999;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_CARD_MAX:  card_max_q <= cfg_ch.data[6:0];
        CFG_EXTRA_MAX: extra_max_q <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  cmp_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  cmp_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_valid_i(q_valid), .q_item_i(q_item),
    .q_pop_o(q_pop), .card_max_i(card_max_q), .extra_max_i(extra_max_q),
    .out_ch(out_ch)
  );
endmodule

// File: rtl/core/cmp_checker.sv
// Port-level checker of the card message parser, bound to the top level.
`include "assert_macros.svh"
module cmp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input cmp_pkg::out_item_t out_payload_i
);
  import cmp_pkg::*;

  `ASSERT_NEXT(out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_i))
  `ASSERT_IMPL(end_final, clk_i, rst_ni, out_valid_i && out_payload_i.message_end, out_payload_i.status != ST_PENDING)
  `ASSERT_IMPL(role_range, clk_i, rst_ni, out_valid_i, out_payload_i.byte_role <= ROLE_IGNORE)
  `ASSERT_IMPL(hdr_no_elem, clk_i, rst_ni, out_valid_i && out_payload_i.byte_role <= ROLE_BITMAP, out_payload_i.element_number == 7'd0)
endmodule

bind card_message_parser_core cmp_checker u_cmp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready), .out_payload_i(out_ch.payload)
);
